>>> sv/mos_pkg.sv
// Package with the shared types, operation codes and sizes of the two-list median block.
package mos_pkg;

  // Default capacity of each list, in words.
  localparam int unsigned MaxLen = 1024;

  // Operation codes carried in the op field of an input word.
  localparam logic [1:0] OpAppendFirst  = 2'd0;
  localparam logic [1:0] OpAppendSecond = 2'd1;
  localparam logic [1:0] OpCompute      = 2'd2;

  // Input word: operation and the element to append.
  typedef struct packed {
    logic        [1:0]  op;
    logic signed [31:0] value;
  } in_t;

  // Output word: twice the median and the empty flag.
  typedef struct packed {
    logic signed [32:0] median_twice;
    logic               empty_error;
  } out_t;

endpackage

>>> sv/mos_ram.sv
// Simple dual-port memory with one write port and one registered read port.
module mos_ram #(
  parameter int unsigned DEPTH = mos_pkg::MaxLen,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port and registered read port; contents are not reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/median_of_two_sorted_arrays.sv
// Append gives no word; one append word is accepted per cycle while no compute walk is running.
// Compute walks the two-pointer merge, one step per cycle, up to the merge position of the
// upper middle element; the result word is valid in the cycle after the last step.
// Each step is bounded by one registered read from each list memory.
// An empty compute gives its word in the cycle after acceptance.
// Reset clears the state, both counts and the output valid flag; the list memories are not cleared.
module median_of_two_sorted_arrays #(
  parameter int unsigned MAX_LEN = mos_pkg::MaxLen
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mos_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mos_pkg::out_t out_data_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned TW = CW + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, pos_q, pos_d;
  logic signed [31:0] lo_q, lo_d;
  logic out_valid_q, out_valid_d;
  mos_pkg::out_t out_q, out_d;

  logic in_acc;
  logic we_a, we_b;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [31:0] rdata_a, rdata_b;
  logic signed [31:0] head_a, head_b, pick, lo_sel;
  logic take_first;
  logic [TW-1:0] total, total_m1;
  logic [CW-1:0] lo_pos, hi_pos;

  // Input handshake; a compute word waits while a result is still pending.
  assign in_ready_o = (state_q == ST_IDLE) &&
                      (!out_valid_q || (in_data_i.op != mos_pkg::OpCompute));
  assign in_acc = in_valid_i && in_ready_o;

  // Appends write at the current count when the list has room.
  assign we_a = in_acc && (in_data_i.op == mos_pkg::OpAppendFirst) &&
                (cnt_a_q < CW'(MAX_LEN));
  assign we_b = in_acc && (in_data_i.op == mos_pkg::OpAppendSecond) &&
                (cnt_b_q < CW'(MAX_LEN));

  // Merge positions of the two middle elements.
  assign total    = {1'b0, cnt_a_q} + {1'b0, cnt_b_q};
  assign total_m1 = total - TW'(1);
  assign lo_pos   = total_m1[TW-1:1];
  assign hi_pos   = total[TW-1:1];

  // Heads of both lists, read ahead at the next pointers.
  assign head_a = $signed(rdata_a);
  assign head_b = $signed(rdata_b);

  // One merge step: take the first head on a tie.
  always_comb begin
    if (i_q >= cnt_a_q) begin
      take_first = 1'b0;
    end else if (j_q >= cnt_b_q) begin
      take_first = 1'b1;
    end else begin
      take_first = (head_a <= head_b);
    end
  end

  assign pick   = take_first ? head_a : head_b;
  assign lo_sel = (pos_q == lo_pos) ? pick : lo_q;

  // Control and datapath next state.
  always_comb begin
    state_d     = state_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    i_d         = i_q;
    j_d         = j_q;
    pos_d       = pos_q;
    lo_d        = lo_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (we_a) begin
          cnt_a_d = cnt_a_q + CW'(1);
        end
        if (we_b) begin
          cnt_b_d = cnt_b_q + CW'(1);
        end
        if (in_acc && (in_data_i.op == mos_pkg::OpCompute)) begin
          i_d   = '0;
          j_d   = '0;
          pos_d = '0;
          if (total == '0) begin
            out_valid_d        = 1'b1;
            out_d.median_twice = '0;
            out_d.empty_error  = 1'b1;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        i_d   = i_q + CW'(take_first);
        j_d   = j_q + CW'(!take_first);
        pos_d = pos_q + CW'(1);
        lo_d  = lo_sel;
        if (pos_q == hi_pos) begin
          out_valid_d        = 1'b1;
          out_d.median_twice = {lo_sel[31], lo_sel} + {pick[31], pick};
          out_d.empty_error  = 1'b0;
          cnt_a_d            = '0;
          cnt_b_d            = '0;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Read addresses follow the next pointers so data lines up with the step.
  assign raddr_a = (state_q == ST_WALK) ? i_d[AW-1:0] : '0;
  assign raddr_b = (state_q == ST_WALK) ? j_d[AW-1:0] : '0;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk pointers and payload registers.
  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    pos_q <= pos_d;
    lo_q  <= lo_d;
    out_q <= out_d;
  end

  // List storage.
  mos_ram #(
    .DEPTH (MAX_LEN),
    .AW    (AW),
    .DW    (32)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[AW-1:0]),
    .wdata_i (in_data_i.value),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mos_ram #(
    .DEPTH (MAX_LEN),
    .AW    (AW),
    .DW    (32)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[AW-1:0]),
    .wdata_i (in_data_i.value),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/mos_checker.sv
// Port-level checker for the two-list median block, with its bind statement.
module mos_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input mos_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input mos_pkg::out_t out_data_o
);

  // A result word stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped before it was taken");

  // A stalled result word holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("stalled result word changed");

  // After a compute word, the block either offers a result or stalls its input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.op == mos_pkg::OpCompute)
    |=> out_valid_o || !in_ready_o)
    else $error("input taken during a merge walk");

  // Appends never produce a result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o &&
    (in_data_i.op != mos_pkg::OpCompute) |=> !out_valid_o)
    else $error("result word without a compute");

  // The empty flag comes with a zero median.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.empty_error |-> (out_data_o.median_twice == '0))
    else $error("empty result carries a nonzero median");

endmodule

bind median_of_two_sorted_arrays mos_checker u_mos_checker (.*);
